### hdl/fcm_pkg.sv
`timescale 1ns / 1ps
package fcm_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = 5;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_MOVE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] match_count;
    logic [CNT_W-1:0] size_after;
    logic             is_empty;
  } out_t;

endpackage

### hdl/fcm_store.sv
`timescale 1ns / 1ps
module fcm_store (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [fcm_pkg::IDX_W-1:0]          waddr_i,
  input  logic [fcm_pkg::VALUE_WIDTH-1:0]    wdata_i,
  input  logic                               re_i,
  input  logic [fcm_pkg::IDX_W-1:0]          raddr_i,
  output logic [fcm_pkg::VALUE_WIDTH-1:0]    rdata_o
);

  logic [fcm_pkg::VALUE_WIDTH-1:0] mem_q [fcm_pkg::CAPACITY];
  logic [fcm_pkg::VALUE_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fixed_capacity_multiset.sv
`timescale 1ns / 1ps
// Fixed-capacity multiset of up to 16 values held in a single-port-read RAM. Each transfer
// carries an action (add, remove one copy, clear, query) and a value; one result comes back
// per transfer with the success flag, the match count before the action, the size after it
// and an empty flag. One comparator walks the stored entries one per cycle through the RAM
// read port; a remove that finds a match then fetches the last entry through the same port
// and writes it over the first match, and a result still stalled in the output register
// holds the finished item back. Input is stalled while an item is in progress; a finished
// result waits in the output register while the next transfer is taken.
module fixed_capacity_multiset (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fcm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fcm_pkg::out_t out_data_o
);

  localparam int IW = fcm_pkg::IDX_W;
  localparam int CW = fcm_pkg::CNT_W;

  fcm_pkg::state_e  state_q, state_d;
  fcm_pkg::action_e action_q, action_d;
  logic [fcm_pkg::VALUE_WIDTH-1:0] value_q, value_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] match_q, match_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [IW-1:0] first_q, first_d;
  logic          found_q, found_d;
  logic          ok_q, ok_d;
  logic          out_valid_q, out_valid_d;
  fcm_pkg::out_t out_q, out_d;

  logic          we;
  logic [IW-1:0] waddr;
  logic [fcm_pkg::VALUE_WIDTH-1:0] wdata;
  logic          re;
  logic [IW-1:0] raddr;
  logic [fcm_pkg::VALUE_WIDTH-1:0] rdata;
  logic          issue;
  logic [CW-1:0] last;

  fcm_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign issue = (idx_q < count_q);
  assign last  = count_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    value_d     = value_q;
    count_d     = count_q;
    idx_d       = idx_q;
    match_d     = match_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    first_d     = first_q;
    found_d     = found_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = count_q[IW-1:0];
    wdata       = value_q;
    re          = 1'b0;
    raddr       = idx_q[IW-1:0];

    case (state_q)
      fcm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          action_d  = fcm_pkg::action_e'(in_data_i.action);
          value_d   = in_data_i.value[fcm_pkg::VALUE_WIDTH-1:0];
          idx_d     = '0;
          match_d   = '0;
          cmp_vld_d = 1'b0;
          found_d   = 1'b0;
          ok_d      = 1'b0;
          state_d   = fcm_pkg::S_SCAN;
        end
      end
      fcm_pkg::S_SCAN: begin
        re        = issue;
        cmp_vld_d = issue;
        cmp_idx_d = idx_q[IW-1:0];
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (cmp_vld_q && (rdata == value_q)) begin
          match_d = match_q + CW'(1);
          if (!found_q) begin
            found_d = 1'b1;
            first_d = cmp_idx_q;
          end
        end
        if (!issue && !cmp_vld_q) begin
          state_d = fcm_pkg::S_ACT;
        end
      end
      fcm_pkg::S_ACT: begin
        state_d = fcm_pkg::S_DONE;
        case (action_q)
          fcm_pkg::ACT_ADD: begin
            if (count_q < CW'(fcm_pkg::CAPACITY)) begin
              we      = 1'b1;
              count_d = count_q + CW'(1);
              ok_d    = 1'b1;
            end
          end
          fcm_pkg::ACT_REMOVE: begin
            if (found_q) begin
              re      = 1'b1;
              raddr   = last[IW-1:0];
              state_d = fcm_pkg::S_MOVE;
            end
          end
          fcm_pkg::ACT_CLEAR: begin
            count_d = '0;
            ok_d    = 1'b1;
          end
          default: begin
            ok_d = 1'b0;
          end
        endcase
      end
      fcm_pkg::S_MOVE: begin
        we      = 1'b1;
        waddr   = first_q;
        wdata   = rdata;
        count_d = last;
        ok_d    = 1'b1;
        state_d = fcm_pkg::S_DONE;
      end
      fcm_pkg::S_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d       = 1'b1;
          out_d.ok          = ok_q;
          out_d.match_count = match_q;
          out_d.size_after  = count_q;
          out_d.is_empty    = (count_q == '0);
          state_d           = fcm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fcm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcm_pkg::S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      ok_q        <= 1'b0;
      match_q     <= '0;
      out_valid_q <= 1'b0;
      action_q    <= fcm_pkg::ACT_QUERY;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      ok_q        <= ok_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
      action_q    <= action_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    cmp_idx_q <= cmp_idx_d;
    first_q   <= first_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != fcm_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/fcm_checker.sv
`timescale 1ns / 1ps
module fcm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fcm_pkg::out_t out_data_o
);

  localparam int CW = fcm_pkg::CNT_W;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.size_after == '0)))
    else $error("empty flag disagrees with size");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.size_after <= CW'(fcm_pkg::CAPACITY))
                 && (out_data_o.match_count <= CW'(fcm_pkg::CAPACITY)))
    else $error("count beyond capacity");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while item in progress");

endmodule

bind fixed_capacity_multiset fcm_checker u_fcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int POOL_N      = 6;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fcm_pkg::in_t  in_data  = '0;
  logic out_valid;
  logic rx_stall = 1'b0;
  fcm_pkg::out_t out_data;

  always #2 clk_i = ~clk_i;

  fixed_capacity_multiset DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(rx_stall),
    .out_data_o (out_data)
  );

  // Shadow copy of the bag
  logic [fcm_pkg::VALUE_WIDTH-1:0] bag_mem [fcm_pkg::CAPACITY];
  int bag_n = 0;
  fcm_pkg::out_t pending_q[$];

  logic [fcm_pkg::VALUE_WIDTH-1:0] pool [POOL_N];
  int errors = 0;
  int burst_left = 0;
  int cycles = 0;
  int n_add = 0, n_add_full = 0, n_rem = 0, n_rem_miss = 0, n_clear = 0, n_query = 0;
  int n_full_seen = 0, n_empty_seen = 0;
  logic [7:0] rx_cycle = '0;

  function automatic fcm_pkg::out_t predict_bag(fcm_pkg::in_t it);
    fcm_pkg::out_t r;
    int first;
    int hits;
    first = -1;
    hits = 0;
    for (int i = 0; i < bag_n; i++) begin
      if (bag_mem[i] == it.value) begin
        if (first < 0) first = i;
        hits++;
      end
    end
    r.ok = 1'b0;
    case (fcm_pkg::action_e'(it.action))
      fcm_pkg::ACT_ADD: begin
        n_add++;
        if (bag_n < fcm_pkg::CAPACITY) begin
          bag_mem[bag_n] = it.value;
          bag_n++;
          r.ok = 1'b1;
        end else begin
          n_add_full++;
        end
      end
      fcm_pkg::ACT_REMOVE: begin
        n_rem++;
        if (first >= 0) begin
          bag_n--;
          bag_mem[first] = bag_mem[bag_n];
          r.ok = 1'b1;
        end else begin
          n_rem_miss++;
        end
      end
      fcm_pkg::ACT_CLEAR: begin
        n_clear++;
        bag_n = 0;
        r.ok = 1'b1;
      end
      default: n_query++;
    endcase
    if (bag_n == fcm_pkg::CAPACITY) n_full_seen++;
    if (bag_n == 0) n_empty_seen++;
    r.match_count = hits[fcm_pkg::CNT_W-1:0];
    r.size_after  = bag_n[fcm_pkg::CNT_W-1:0];
    r.is_empty    = (bag_n == 0);
    return r;
  endfunction

  task automatic send_item(input fcm_pkg::action_e act,
                           input logic [fcm_pkg::VALUE_WIDTH-1:0] val);
    fcm_pkg::in_t it;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    it.action = act;
    it.value  = val;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    pending_q = {pending_q, predict_bag(it)};
  endtask

  // hold off until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  task automatic check_result(input fcm_pkg::out_t got);
    fcm_pkg::out_t want;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result with nothing pending: ok=%0b match=%0d size=%0d empty=%0b",
                 $realtime, got.ok, got.match_count, got.size_after, got.is_empty);
      return;
    end
    want = pending_q.pop_front();
    if (got.ok !== want.ok || got.match_count !== want.match_count ||
        got.size_after !== want.size_after || got.is_empty !== want.is_empty) begin
      errors++;
      if (errors <= 10)
        $display("%0t: exp ok=%0b match=%0d size=%0d empty=%0b got %0b %0d %0d %0b",
                 $realtime, want.ok, want.match_count, want.size_after, want.is_empty,
                 got.ok, got.match_count, got.size_after, got.is_empty);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !rx_stall) check_result(out_data);
  end

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 8'd1;
    case (rx_cycle[7:6])
      2'd0:    rx_stall <= 1'b0;
      2'd1:    rx_stall <= ($urandom_range(0, 2) == 0);
      2'd2:    rx_stall <= (rx_cycle[2:0] < 3'd5);
      default: rx_stall <= (rx_cycle[4:0] < 5'd14);
    endcase
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
      $display("** fixed_capacity_multiset: FAILED **");
      $finish;
    end
  end

  function automatic logic [fcm_pkg::VALUE_WIDTH-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  function automatic logic [fcm_pkg::VALUE_WIDTH-1:0] pick_stored();
    if (bag_n > 0 && $urandom_range(0, 3) != 0) return bag_mem[$urandom_range(0, bag_n - 1)];
    return pick_value();
  endfunction

  task automatic test_empty_bag();
    send_item(fcm_pkg::ACT_REMOVE, 32'h0000_0005);
    send_item(fcm_pkg::ACT_CLEAR,  32'h0000_0000);
    send_item(fcm_pkg::ACT_QUERY,  32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_add_remove();
    send_item(fcm_pkg::ACT_ADD,    32'h0000_0000);
    send_item(fcm_pkg::ACT_ADD,    32'hFFFF_FFFF);
    send_item(fcm_pkg::ACT_ADD,    32'h0000_0000);
    send_item(fcm_pkg::ACT_QUERY,  32'h0000_0000);
    send_item(fcm_pkg::ACT_REMOVE, 32'h0000_0000);
    send_item(fcm_pkg::ACT_REMOVE, 32'h1234_5678);
    send_item(fcm_pkg::ACT_REMOVE, 32'hFFFF_FFFF);
    drain();
  endtask

  // one zero is left over, so the bag fills with sixteen equal entries before the refused add and the clear
  task automatic test_full_bag();
    repeat (fcm_pkg::CAPACITY - 1) send_item(fcm_pkg::ACT_ADD, 32'h0000_0000);
    send_item(fcm_pkg::ACT_ADD,   32'h0000_0000);
    send_item(fcm_pkg::ACT_CLEAR, 32'h0000_0000);
    drain();
  endtask

  task automatic test_random_mix();
    int r;
    bit grow;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) pool[i] = $urandom;
    for (int ph = 0; ph < 11; ph++) begin
      grow = (ph % 2 == 0);
      for (int k = 0; k < 50; k++) begin
        r = $urandom_range(0, 99);
        if (r < (grow ? 65 : 25))       send_item(fcm_pkg::ACT_ADD, pick_value());
        else if (r < 85)                send_item(fcm_pkg::ACT_REMOVE, pick_stored());
        else if (r < (grow ? 98 : 97))  send_item(fcm_pkg::ACT_QUERY, pick_stored());
        else                            send_item(fcm_pkg::ACT_CLEAR, pick_value());
      end
      if ($urandom_range(0, 2) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_bag();
    test_add_remove();
    test_full_bag();
    test_random_mix();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_q.size() != 0) errors += pending_q.size();
    $display("Covered %0d adds (%0d refused when full), %0d removes (%0d with no match),",
             n_add, n_add_full, n_rem, n_rem_miss);
    $display("  %0d clears, %0d plain queries; bag full after %0d and empty after %0d transfers",
             n_clear, n_query, n_full_seen, n_empty_seen);
    if (errors == 0) begin
      $display("** fixed_capacity_multiset: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** fixed_capacity_multiset: FAILED **");
    end
    $finish;
  end

endmodule

### fixed_capacity_multiset.f
hdl/fcm_pkg.sv
hdl/fcm_store.sv
hdl/fixed_capacity_multiset.sv
hdl/fcm_checker.sv
sim/tb_top.sv
